// File: rtl/slpc_pkg.sv
// slpc_pkg: shared types, constants and helpers of the status line parser
// used by slpc_line_core and status_line_parse_check; no dependencies
`default_nettype none

package slpc_pkg;

    localparam int LINE_LIMIT   = 1023;
    localparam int LINE_COUNT_W = 10;
    localparam int MIN_LINE_BYTES = 4;
    localparam int VALUE_W      = 15;
    localparam int VALVE_W      = 7;
    localparam int TOKEN_W      = 4;
    localparam int NUM_FIELDS   = 4;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 15'h7FFF;
    localparam logic [TOKEN_W-1:0] TOKEN_MAX = 4'd15;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_A     = 8'h41;

    localparam logic [TOKEN_W-1:0] TOKEN_HEADER  = 4'd0;
    localparam logic [TOKEN_W-1:0] TOKEN_MODE    = 4'd4;
    localparam logic [TOKEN_W-1:0] TOKEN_VALVE   = 4'd6;
    localparam logic [TOKEN_W-1:0] TOKEN_MEAS    = 4'd8;
    localparam logic [TOKEN_W-1:0] TOKEN_SETP    = 4'd10;
    localparam logic [TOKEN_W-1:0] TOKEN_BATTERY = 4'd12;

    typedef enum logic [1:0] {
        FIELD_VALVE   = 2'd0,
        FIELD_MEAS    = 2'd1,
        FIELD_SETP    = 2'd2,
        FIELD_BATTERY = 2'd3
    } field_num_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MEASURED_LOW  = 3'd0,
        REG_MEASURED_HIGH = 3'd1,
        REG_SETPOINT_LOW  = 3'd2,
        REG_SETPOINT_HIGH = 3'd3,
        REG_BATTERY_LOW   = 3'd4,
        REG_BATTERY_HIGH  = 3'd5,
        REG_VALVE_HIGH    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] measured_low;
        logic [VALUE_W-1:0] measured_high;
        logic [VALUE_W-1:0] setpoint_low;
        logic [VALUE_W-1:0] setpoint_high;
        logic [VALUE_W-1:0] battery_low;
        logic [VALUE_W-1:0] battery_high;
        logic [VALVE_W-1:0] valve_high;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        mode_t              mode;
        logic [VALVE_W-1:0] valve;
        logic [VALUE_W-1:0] measured;
        logic [VALUE_W-1:0] setpoint;
        logic [VALUE_W-1:0] battery;
    } result_t;

    typedef struct packed {
        logic       hit;
        field_num_t num;
    } field_sel_t;

    function automatic field_sel_t field_of_token(input logic [TOKEN_W-1:0] idx);
        field_sel_t sel;
        sel.hit = 1'b1;
        sel.num = FIELD_VALVE;
        case (idx)
            TOKEN_VALVE:   sel.num = FIELD_VALVE;
            TOKEN_MEAS:    sel.num = FIELD_MEAS;
            TOKEN_SETP:    sel.num = FIELD_SETP;
            TOKEN_BATTERY: sel.num = FIELD_BATTERY;
            default:       sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// File: rtl/slpc_line_core.sv
// slpc_line_core: per-byte tokenizer, number reader, line checks and stored values
// depends on slpc_pkg; stepped by status_line_parse_check
`default_nettype none

module slpc_line_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data,
    input  wire slpc_pkg::cfg_t  cfg,
    output logic                 line_end,
    output slpc_pkg::result_t    res
);
    import slpc_pkg::*;

    logic [LINE_COUNT_W-1:0] line_count_reg, line_count_next;
    logic [TOKEN_W-1:0]      token_number_reg, token_number_next;
    logic                    inside_token_reg, inside_token_next;
    logic                    token_start_reg, token_start_next;
    logic                    header_good_reg, header_good_next;
    logic [VALUE_W-1:0]      number_value_reg, number_value_next;
    logic                    number_negative_reg, number_negative_next;
    logic                    number_ended_reg, number_ended_next;
    mode_t                   line_mode_reg, line_mode_next;
    logic [VALUE_W-1:0]      line_fields_reg [NUM_FIELDS];
    logic [VALUE_W-1:0]      line_fields_next [NUM_FIELDS];
    logic [NUM_FIELDS-1:0]   fields_present_reg, fields_present_next;
    logic [NUM_FIELDS-1:0]   field_bad_reg, field_bad_next;
    mode_t                   kept_mode_reg, kept_mode_next;
    logic [VALUE_W-1:0]      kept_values_reg [NUM_FIELDS];
    logic [VALUE_W-1:0]      kept_values_next [NUM_FIELDS];

    // number committed when the current token closes
    field_sel_t            cur_sel;
    logic                  commit_hit;
    logic [NUM_FIELDS-1:0] commit_bad;
    logic [VALUE_W-1:0]    fields_commit [NUM_FIELDS];
    logic                  line_ok;

    assign line_end = (data == CHAR_NL) || (line_count_reg >= LINE_COUNT_W'(LINE_LIMIT));

    always_comb
    begin
        cur_sel = field_of_token(token_number_reg - TOKEN_W'(1));
        commit_hit = inside_token_reg && (token_number_reg != '0) && cur_sel.hit;
        commit_bad = field_bad_reg;
        if (commit_hit && number_negative_reg && (number_value_reg != '0))
        begin
            commit_bad[cur_sel.num] = 1'b1;
        end
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            fields_commit[i] = (commit_hit && (cur_sel.num == field_num_t'(i)))
                               ? number_value_reg : line_fields_reg[i];
        end
        line_ok = (line_count_reg >= LINE_COUNT_W'(MIN_LINE_BYTES)) && header_good_reg &&
                  (line_mode_reg != MODE_NONE) && (fields_present_reg == '1) &&
                  (commit_bad == '0) &&
                  (fields_commit[FIELD_VALVE] <= {{(VALUE_W-VALVE_W){1'b0}}, cfg.valve_high}) &&
                  (fields_commit[FIELD_MEAS] >= cfg.measured_low) &&
                  (fields_commit[FIELD_MEAS] <= cfg.measured_high) &&
                  (fields_commit[FIELD_SETP] >= cfg.setpoint_low) &&
                  (fields_commit[FIELD_SETP] <= cfg.setpoint_high) &&
                  (fields_commit[FIELD_BATTERY] >= cfg.battery_low) &&
                  (fields_commit[FIELD_BATTERY] <= cfg.battery_high);
    end

    always_comb
    begin
        logic               new_tok;
        logic [TOKEN_W-1:0] idx_cur;
        field_sel_t         sel_new;
        field_sel_t         sel_cur;
        logic [18:0]        acc;
        logic               do_digit;

        new_tok  = 1'b0;
        idx_cur  = '0;
        sel_new  = '0;
        sel_cur  = '0;
        acc      = '0;
        do_digit = 1'b0;

        line_count_next      = line_count_reg;
        token_number_next    = token_number_reg;
        inside_token_next    = inside_token_reg;
        token_start_next     = token_start_reg;
        header_good_next     = header_good_reg;
        number_value_next    = number_value_reg;
        number_negative_next = number_negative_reg;
        number_ended_next    = number_ended_reg;
        line_mode_next       = line_mode_reg;
        fields_present_next  = fields_present_reg;
        field_bad_next       = field_bad_reg;
        kept_mode_next       = kept_mode_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            line_fields_next[i] = line_fields_reg[i];
            kept_values_next[i] = kept_values_reg[i];
        end

        if (step && line_end)
        begin
            if (line_ok)
            begin
                kept_mode_next = line_mode_reg;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    kept_values_next[i] = fields_commit[i];
                end
            end
            line_count_next      = '0;
            token_number_next    = '0;
            inside_token_next    = 1'b0;
            token_start_next     = 1'b0;
            header_good_next     = 1'b0;
            number_value_next    = '0;
            number_negative_next = 1'b0;
            number_ended_next    = 1'b0;
            line_mode_next       = MODE_NONE;
            fields_present_next  = '0;
            field_bad_next       = '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                line_fields_next[i] = '0;
            end
        end
        else if (step && (data != CHAR_NUL))
        begin
            line_count_next = line_count_reg + LINE_COUNT_W'(1);
            if (data == CHAR_SPACE)
            begin
                // separator closes the token
                field_bad_next    = commit_bad;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    line_fields_next[i] = fields_commit[i];
                end
                inside_token_next = 1'b0;
            end
            else
            begin
                new_tok = !inside_token_reg;
                idx_cur = new_tok ? token_number_reg : (token_number_reg - TOKEN_W'(1));
                if (new_tok)
                begin
                    if (token_number_reg != TOKEN_MAX)
                    begin
                        token_number_next = token_number_reg + TOKEN_W'(1);
                    end
                    inside_token_next = 1'b1;
                    if (token_number_reg == TOKEN_HEADER)
                    begin
                        header_good_next = (data == CHAR_D);
                    end
                    if (token_number_reg == TOKEN_MODE)
                    begin
                        line_mode_next = (data == CHAR_M) ? MODE_MANUAL :
                                         (data == CHAR_A) ? MODE_AUTO : MODE_NONE;
                    end
                    sel_new = field_of_token(token_number_reg);
                    if (sel_new.hit)
                    begin
                        fields_present_next[sel_new.num] = 1'b1;
                        number_value_next    = '0;
                        number_negative_next = 1'b0;
                        number_ended_next    = 1'b0;
                        token_start_next     = 1'b1;
                    end
                end

                sel_cur = field_of_token(idx_cur);
                if (sel_cur.hit && !number_ended_next)
                begin
                    if (token_start_next)
                    begin
                        if (data inside {[CHAR_TAB:CHAR_CR]})
                        begin
                            token_start_next = 1'b1;
                        end
                        else if ((data == CHAR_PLUS) || (data == CHAR_MINUS))
                        begin
                            token_start_next     = 1'b0;
                            number_negative_next = (data == CHAR_MINUS);
                        end
                        else if (data inside {[CHAR_ZERO:CHAR_NINE]})
                        begin
                            token_start_next = 1'b0;
                            do_digit         = 1'b1;
                        end
                        else
                        begin
                            number_ended_next = 1'b1;
                        end
                    end
                    else if (data inside {[CHAR_ZERO:CHAR_NINE]})
                    begin
                        do_digit = 1'b1;
                    end
                    else
                    begin
                        number_ended_next = 1'b1;
                    end
                end

                if (do_digit)
                begin
                    // value * 10 + digit, saturating
                    acc = ({4'b0, number_value_next} << 3) + ({4'b0, number_value_next} << 1)
                          + {15'b0, 4'(data - CHAR_ZERO)};
                    if (acc > {4'b0, VALUE_MAX})
                    begin
                        number_value_next = VALUE_MAX;
                        field_bad_next[sel_cur.num] = 1'b1;
                    end
                    else
                    begin
                        number_value_next = acc[VALUE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg      <= '0;
            token_number_reg    <= '0;
            inside_token_reg    <= 1'b0;
            token_start_reg     <= 1'b0;
            header_good_reg     <= 1'b0;
            number_value_reg    <= '0;
            number_negative_reg <= 1'b0;
            number_ended_reg    <= 1'b0;
            line_mode_reg       <= MODE_NONE;
            fields_present_reg  <= '0;
            field_bad_reg       <= '0;
            kept_mode_reg       <= MODE_NONE;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                line_fields_reg[i] <= '0;
                kept_values_reg[i] <= '0;
            end
        end
        else
        begin
            line_count_reg      <= line_count_next;
            token_number_reg    <= token_number_next;
            inside_token_reg    <= inside_token_next;
            token_start_reg     <= token_start_next;
            header_good_reg     <= header_good_next;
            number_value_reg    <= number_value_next;
            number_negative_reg <= number_negative_next;
            number_ended_reg    <= number_ended_next;
            line_mode_reg       <= line_mode_next;
            fields_present_reg  <= fields_present_next;
            field_bad_reg       <= field_bad_next;
            kept_mode_reg       <= kept_mode_next;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                line_fields_reg[i] <= line_fields_next[i];
                kept_values_reg[i] <= kept_values_next[i];
            end
        end
    end

    always_comb
    begin
        res.accepted = line_ok;
        res.mode     = kept_mode_next;
        res.valve    = kept_values_next[FIELD_VALVE][VALVE_W-1:0];
        res.measured = kept_values_next[FIELD_MEAS];
        res.setpoint = kept_values_next[FIELD_SETP];
        res.battery  = kept_values_next[FIELD_BATTERY];
    end

endmodule

`default_nettype wire

// File: rtl/status_line_parse_check.sv
// status_line_parse_check: top level with byte input stage, settings registers
// and result registers; depends on slpc_pkg and slpc_line_core
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in       | in_valid / in_ready  | rx_byte
//  out      | out_valid / out_ready| line_accepted, mode_now, valve_now,
//           |                      | measured_now, setpoint_now, battery_now
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one byte per cycle unless a line-end byte waits: a request lands in the input
// register, then the tokenizer updates its state and, at a line end, loads a
// result register. two result registers keep out_ready off the input path; a
// line-end byte waits in the input register only while both are full.
// reset clears line state, stored values and loads the default limits.
// cfg_ready is always high; writes to index 7 are ignored.
`default_nettype none

module status_line_parse_check (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   line_accepted,
    output logic [1:0]                             mode_now,
    output logic [slpc_pkg::VALVE_W-1:0]           valve_now,
    output logic [slpc_pkg::VALUE_W-1:0]           measured_now,
    output logic [slpc_pkg::VALUE_W-1:0]           setpoint_now,
    output logic [slpc_pkg::VALUE_W-1:0]           battery_now,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [slpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [slpc_pkg::VALUE_W-1:0]      cfg_data
);
    import slpc_pkg::*;

    cfg_t       cfg_reg;
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       skid_valid_reg;
    result_t    skid_reg;

    logic       stage_go;
    logic       core_end;
    result_t    core_res;
    logic       res_push;
    logic       res_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.measured_low  <= VALUE_W'(500);
            cfg_reg.measured_high <= VALUE_W'(4000);
            cfg_reg.setpoint_low  <= VALUE_W'(500);
            cfg_reg.setpoint_high <= VALUE_W'(3000);
            cfg_reg.battery_low   <= VALUE_W'(2000);
            cfg_reg.battery_high  <= VALUE_W'(4000);
            cfg_reg.valve_high    <= VALVE_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MEASURED_LOW:  cfg_reg.measured_low  <= cfg_data;
                REG_MEASURED_HIGH: cfg_reg.measured_high <= cfg_data;
                REG_SETPOINT_LOW:  cfg_reg.setpoint_low  <= cfg_data;
                REG_SETPOINT_HIGH: cfg_reg.setpoint_high <= cfg_data;
                REG_BATTERY_LOW:   cfg_reg.battery_low   <= cfg_data;
                REG_BATTERY_HIGH:  cfg_reg.battery_high  <= cfg_data;
                REG_VALVE_HIGH:    cfg_reg.valve_high    <= cfg_data[VALVE_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // a line-end byte needs a free result slot
    assign stage_go = stage_valid_reg && (!core_end || !skid_valid_reg);
    assign in_ready = !stage_valid_reg || stage_go;
    assign res_push = stage_go && core_end;
    assign res_pop  = out_valid_reg && out_ready;

    slpc_line_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (stage_go),
        .data     (stage_byte_reg),
        .cfg      (cfg_reg),
        .line_end (core_end),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_go)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (!out_valid_reg)
            begin
                out_valid_reg <= res_push;
            end
            else if (res_pop)
            begin
                out_valid_reg <= skid_valid_reg || res_push;
            end
            if (out_valid_reg && !res_pop && res_push)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= rx_byte;
        end
        if (res_push && (!out_valid_reg || res_pop))
        begin
            out_reg <= core_res;
        end
        else if (res_pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        if (res_push && out_valid_reg && !res_pop)
        begin
            skid_reg <= core_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_accepted = out_reg.accepted;
    assign mode_now      = out_reg.mode;
    assign valve_now     = out_reg.valve;
    assign measured_now  = out_reg.measured;
    assign setpoint_now  = out_reg.setpoint;
    assign battery_now   = out_reg.battery;

endmodule

`default_nettype wire
